>>> sv/lkvc_pkg.sv
package lkvc_pkg;

    localparam int CAP_BITS = 4;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_SET = 1'b1
    } req_type_t;

    typedef struct packed {
        logic was_hit;
        logic did_evict;
    } lkvc_status_t;

endpackage

>>> sv/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement,
// holding up to MAX_ENTRIES entries in registers. A get that hits returns
// the stored value; a get that misses installs the supplied fill value and
// returns it; a set updates or inserts. Every access makes its entry the
// most recent. Once the entries in use reach the capacity register (zero
// acts as one, values above MAX_ENTRIES act as MAX_ENTRIES), an insert
// evicts the least recent entry and reports its key. The block accepts one
// word per cycle while the receiver does not stall the result register;
// each word passes through the input register, then a single pass of
// parallel key compare and age update over all entries into the result
// register. Capacity may be written only while the block is idle.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 8,
    parameter int KEY_BITS    = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lkvc_pkg::CAP_BITS-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lkvc_pkg::req_type_t            s_req_type,
    input  logic [KEY_BITS-1:0]            s_lookup_key,
    input  logic [VALUE_BITS-1:0]          s_data_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [VALUE_BITS-1:0]          m_read_value,
    output logic                           m_was_hit,
    output logic                           m_did_evict,
    output logic [KEY_BITS-1:0]            m_evicted_key
);
    import lkvc_pkg::*;

    logic [CAP_BITS-1:0]   capacity_reg;
    logic                  fire;
    logic                  out_ready;
    req_type_t             req_type;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] data_value;
    logic [VALUE_BITS-1:0] read_value;
    lkvc_status_t          status;
    logic [KEY_BITS-1:0]   evicted_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    lkvc_in_stage #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_lookup_key (s_lookup_key),
        .s_data_value (s_data_value),
        .out_ready    (out_ready),
        .fire         (fire),
        .req_type     (req_type),
        .lookup_key   (lookup_key),
        .data_value   (data_value)
    );

    lkvc_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .req_type    (req_type),
        .lookup_key  (lookup_key),
        .data_value  (data_value),
        .capacity    (capacity_reg),
        .read_value  (read_value),
        .status      (status),
        .evicted_key (evicted_key)
    );

    lkvc_out_stage #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .read_value    (read_value),
        .status        (status),
        .evicted_key   (evicted_key),
        .out_ready     (out_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_was_hit     (m_was_hit),
        .m_did_evict   (m_did_evict),
        .m_evicted_key (m_evicted_key)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_was_hit && m_did_evict))
        else $error("Result reports both a hit and an eviction.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_did_evict) |-> (m_evicted_key == '0))
        else $error("Evicted key is nonzero without an eviction.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("A processed word did not reach the result register.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && status.was_hit && (req_type == REQ_SET)) |-> (read_value == data_value))
        else $error("A set hit does not return the written value.");

endmodule

>>> sv/lkvc_in_stage.sv
module lkvc_in_stage #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lkvc_pkg::req_type_t    s_req_type,
    input  logic [KEY_BITS-1:0]    s_lookup_key,
    input  logic [VALUE_BITS-1:0]  s_data_value,
    input  logic                   out_ready,
    output logic                   fire,
    output lkvc_pkg::req_type_t    req_type,
    output logic [KEY_BITS-1:0]    lookup_key,
    output logic [VALUE_BITS-1:0]  data_value
);
    import lkvc_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    req_type_t       type_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] data_reg;
    logic            load;

    assign fire    = valid_reg && out_ready;
    assign s_ready = !valid_reg || out_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            type_reg <= s_req_type;
            key_reg  <= s_lookup_key;
            data_reg <= s_data_value;
        end
    end

    assign req_type   = type_reg;
    assign lookup_key = key_reg;
    assign data_value = data_reg;

endmodule

>>> sv/lkvc_store.sv
module lkvc_store #(
    parameter int MAX_ENTRIES = 8,
    parameter int KEY_BITS    = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  lkvc_pkg::req_type_t             req_type,
    input  logic [KEY_BITS-1:0]             lookup_key,
    input  logic [VALUE_BITS-1:0]           data_value,
    input  logic [lkvc_pkg::CAP_BITS-1:0]   capacity,
    output logic [VALUE_BITS-1:0]           read_value,
    output lkvc_pkg::lkvc_status_t          status,
    output logic [KEY_BITS-1:0]             evicted_key
);
    import lkvc_pkg::*;

    localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [AGE_W-1:0]       age_reg   [MAX_ENTRIES];
    logic [AGE_W-1:0]       age_next  [MAX_ENTRIES];
    logic [KEY_BITS-1:0]    key_reg   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]  value_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]       used_reg;
    logic [CNT_W-1:0]       used_next;

    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] lru_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] wr_vec;
    logic                   hit;
    logic                   evict;
    logic                   free_found;
    logic [VALUE_BITS-1:0]  hit_value;
    logic [AGE_W-1:0]       hit_age;
    logic [KEY_BITS-1:0]    lru_key;
    logic [AGE_W-1:0]       last_age;
    logic [CMP_W-1:0]       cap_x;
    logic [CMP_W-1:0]       eff_cap;
    logic                   write_value;

    // Valid ages always form 0 .. used-1, so the least recent entry has age used-1.
    assign last_age = AGE_W'(used_reg - CNT_W'(1));
    assign cap_x    = CMP_W'(capacity);

    always_comb begin
        if (capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_x > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
    end

    always_comb begin
        hit_value  = '0;
        hit_age    = '0;
        lru_key    = '0;
        free_found = 1'b0;
        free_vec   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == lookup_key);
            lru_vec[i] = valid_reg[i] && (age_reg[i] == last_age);
            if (hit_vec[i]) begin
                hit_value = hit_value | value_reg[i];
                hit_age   = hit_age | age_reg[i];
            end
            if (lru_vec[i]) begin
                lru_key = lru_key | key_reg[i];
            end
            if (!valid_reg[i] && !free_found) begin
                free_vec[i] = 1'b1;
                free_found  = 1'b1;
            end
        end
    end

    assign hit   = |hit_vec;
    assign evict = !hit && (CMP_W'(used_reg) >= eff_cap);

    always_comb begin
        if (hit) begin
            wr_vec = hit_vec;
        end else if (evict) begin
            wr_vec = lru_vec;
        end else begin
            wr_vec = free_vec;
        end
    end

    assign write_value = !hit || (req_type == REQ_SET);

    always_comb begin
        valid_next = valid_reg;
        used_next  = used_reg;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            age_next[i] = age_reg[i];
            if (wr_vec[i]) begin
                valid_next[i] = 1'b1;
                age_next[i]   = '0;
            end else if (valid_reg[i] && (!hit || (age_reg[i] < hit_age))) begin
                age_next[i] = age_reg[i] + AGE_W'(1);
            end
        end
        if (!hit && !evict) begin
            used_next = used_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else if (fire) begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (fire && wr_vec[i]) begin
                if (!hit) begin
                    key_reg[i] <= lookup_key;
                end
                if (write_value) begin
                    value_reg[i] <= data_value;
                end
            end
        end
    end

    assign read_value       = write_value ? data_value : hit_value;
    assign status.was_hit   = hit;
    assign status.did_evict = evict;
    assign evicted_key      = evict ? lru_key : '0;

endmodule

>>> sv/lkvc_out_stage.sv
module lkvc_out_stage #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  logic [VALUE_BITS-1:0]    read_value,
    input  lkvc_pkg::lkvc_status_t   status,
    input  logic [KEY_BITS-1:0]      evicted_key,
    output logic                     out_ready,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [VALUE_BITS-1:0]    m_read_value,
    output logic                     m_was_hit,
    output logic                     m_did_evict,
    output logic [KEY_BITS-1:0]      m_evicted_key
);
    import lkvc_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [VALUE_BITS-1:0] value_reg;
    lkvc_status_t          status_reg;
    logic [KEY_BITS-1:0]   ev_key_reg;

    assign out_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            value_reg  <= read_value;
            status_reg <= status;
            ev_key_reg <= evicted_key;
        end
    end

    assign m_valid       = valid_reg;
    assign m_read_value  = value_reg;
    assign m_was_hit     = status_reg.was_hit;
    assign m_did_evict   = status_reg.did_evict;
    assign m_evicted_key = ev_key_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import lkvc_pkg::*;

    localparam int CACHE_DEPTH = 8;
    localparam int HOLD_CYCLES = 90;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [31:0] read_value;
        logic        was_hit;
        logic        did_evict;
        logic [15:0] evicted_key;
    } cache_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CAP_BITS-1:0] cfg_wr_data   = CAP_RESET;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    req_type_t           s_req_type    = REQ_GET;
    logic [15:0]         s_lookup_key  = '0;
    logic [31:0]         s_data_value  = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [31:0]         m_read_value;
    logic                m_was_hit;
    logic                m_did_evict;
    logic [15:0]         m_evicted_key;

    // Shadow copy of the cache contents and the capacity register.
    bit                  ent_valid [CACHE_DEPTH];
    logic [15:0]         ent_key   [CACHE_DEPTH];
    logic [31:0]         ent_value [CACHE_DEPTH];
    int unsigned         ent_age   [CACHE_DEPTH];
    int                  used_entries   = 0;
    logic [CAP_BITS-1:0] cache_capacity = CAP_RESET;

    cache_result_t       expected_results [$];

    int  cycle_count   = 0;
    int  error_count   = 0;
    int  words_sent    = 0;
    int  words_checked = 0;
    int  hits_seen     = 0;
    int  evictions     = 0;
    int  cap_writes    = 0;
    int  burst_left    = 0;
    bit  tx_on         = 1'b0;
    bit  tx_gaps_on    = 1'b1;
    int  rx_mode       = 0;
    int  rx_cycle      = 0;
    logic rx_hold      = 1'b0;
    event rx_hold_go;

    lru_key_value_cache #(
        .MAX_ENTRIES(CACHE_DEPTH),
        .KEY_BITS   (16),
        .VALUE_BITS (32)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_lookup_key (s_lookup_key),
        .s_data_value (s_data_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_was_hit    (m_was_hit),
        .m_did_evict  (m_did_evict),
        .m_evicted_key(m_evicted_key)
    );

    always #6 aclk = ~aclk;

    function automatic void age_entries(input int slot, input int unsigned old_age);
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (ent_valid[i] && i != slot && ent_age[i] < old_age) begin
                ent_age[i]++;
            end
        end
        ent_age[slot] = 0;
    endfunction

    function automatic cache_result_t predict_access(input req_type_t kind,
                                                     input logic [15:0] key,
                                                     input logic [31:0] data);
        cache_result_t res;
        int slot;
        int limit;
        res = '0;
        slot = -1;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (slot < 0 && ent_valid[i] && ent_key[i] == key) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            res.was_hit = 1'b1;
            age_entries(slot, ent_age[slot]);
            if (kind == REQ_SET) begin
                ent_value[slot] = data;
            end
            res.read_value = ent_value[slot];
            hits_seen++;
        end else begin
            limit = (cache_capacity == 0) ? 1 :
                    (cache_capacity > CACHE_DEPTH) ? CACHE_DEPTH : int'(cache_capacity);
            if (used_entries >= limit) begin
                for (int i = 0; i < CACHE_DEPTH; i++) begin
                    if (ent_valid[i] && (slot < 0 || ent_age[i] > ent_age[slot])) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    res.did_evict = 1'b1;
                    res.evicted_key = ent_key[slot];
                    ent_valid[slot] = 1'b0;
                    used_entries--;
                    evictions++;
                end
            end
            if (slot < 0) begin
                for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
                    if (!ent_valid[i]) begin
                        slot = i;
                    end
                end
            end
            ent_valid[slot] = 1'b1;
            ent_key[slot] = key;
            ent_value[slot] = data;
            used_entries++;
            age_entries(slot, 32'hFFFF_FFFF);
            res.read_value = data;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("MISMATCH word %0d %s: got %h expected %h", words_checked, what, got,
                     want);
        end
    endtask

    task automatic check_result();
        cache_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", m_read_value, 32'h0);
        end else begin
            want = expected_results.pop_front();
            if (m_read_value !== want.read_value) begin
                report_mismatch("read_value", m_read_value, want.read_value);
            end
            if (m_was_hit !== want.was_hit) begin
                report_mismatch("was_hit", 32'(m_was_hit), 32'(want.was_hit));
            end
            if (m_did_evict !== want.did_evict) begin
                report_mismatch("did_evict", 32'(m_did_evict), 32'(want.did_evict));
            end
            if (m_evicted_key !== want.evicted_key) begin
                report_mismatch("evicted_key", 32'(m_evicted_key), 32'(want.evicted_key));
            end
        end
        words_checked++;
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
                     expected_results.size());
            $display("tb_top failed");
            $finish;
        end else if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            check_result();
        end
    end

    // The receiver switches at random between four stall patterns.
    always @(posedge aclk) begin
        if (rx_cycle == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_cycle = $urandom_range(20, 80);
        end else begin
            rx_cycle--;
        end
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 1) != 0);
                end
                2: begin
                    m_ready <= ((rx_cycle % 4) != 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    initial begin
        forever begin
            @(rx_hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
    end

    task automatic send_request(input req_type_t kind, input logic [15:0] key,
                                input logic [31:0] data);
        int gap;
        if (!tx_on) begin
            s_valid <= 1'b1;
            tx_on = 1'b1;
        end
        s_req_type   <= kind;
        s_lookup_key <= key;
        s_data_value <= data;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        expected_results.push_back(predict_access(kind, key, data));
        words_sent++;
        if (tx_gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                tx_on = 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
                                                    $urandom_range(1, 4);
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic stop_sending();
        if (tx_on) begin
            s_valid <= 1'b0;
            tx_on = 1'b0;
        end
        burst_left = 0;
    endtask

    task automatic set_capacity(input logic [CAP_BITS-1:0] value);
        stop_sending();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cache_capacity = value;
        cap_writes++;
    endtask

    task automatic test_get_and_set();
        send_request(REQ_GET, 16'h0000, 32'h0000_0000);
        send_request(REQ_GET, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_SET, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_GET, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_SET, 16'hFFFF, 32'h0000_0000);
    endtask

    task automatic test_capacity_floor();
        set_capacity(4'd0);
        send_request(REQ_SET, 16'h8000, 32'h0000_0001);
        send_request(REQ_GET, 16'h8000, 32'hDEAD_BEEF);
        set_capacity(4'd1);
        send_request(REQ_GET, 16'h0001, 32'h8000_0000);
        send_request(REQ_SET, 16'h7FFF, 32'hA5A5_A5A5);
    endtask

    task automatic test_lru_replacement();
        set_capacity(4'd4);
        send_request(REQ_GET, 16'h0100, 32'h1111_1111);
        send_request(REQ_SET, 16'h0200, 32'h2222_2222);
        send_request(REQ_GET, 16'h7FFF, 32'h0);
        send_request(REQ_SET, 16'h0300, 32'h3333_3333);
        send_request(REQ_GET, 16'h0200, 32'h0);
        send_request(REQ_SET, 16'h0400, 32'h4444_4444);
        send_request(REQ_GET, 16'h0100, 32'h5555_5555);
    endtask

    task automatic test_backpressure();
        set_capacity(4'd8);
        tx_gaps_on = 1'b0;
        -> rx_hold_go;
        repeat (36) begin
            send_request(($urandom_range(0, 1) != 0) ? REQ_SET : REQ_GET,
                         16'h0A00 + 16'($urandom_range(0, 11)), $urandom);
        end
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [CAP_BITS-1:0] phase_caps [10];
        logic [15:0]         key_pool   [16];
        int                  pool_size;
        logic [15:0]         key;
        phase_caps = '{4'd5, 4'd6, 4'd7, 4'd8, 4'd15, 4'd9, 4'd2, 4'd0, 4'd12, 4'd3};
        for (int p = 0; p < 10; p++) begin
            set_capacity(phase_caps[p]);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(3, 16);
            for (int k = 0; k < 16; k++) begin
                key_pool[k] = 16'($urandom);
            end
            repeat (40) begin
                if ($urandom_range(0, 4) == 0) begin
                    key = 16'($urandom);
                end else begin
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                end
                send_request(($urandom_range(0, 1) != 0) ? REQ_SET : REQ_GET, key, $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_get_and_set();
        test_capacity_floor();
        test_lru_replacement();
        test_backpressure();
        test_random_traffic();
        stop_sending();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d requests over %0d capacity settings: %0d hits, %0d evictions.",
                 words_sent, cap_writes, hits_seen, evictions);
        $display("Checked %0d result words, including a %0d-cycle receiver hold-off.",
                 words_checked, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
